FILE: hw/rtl/sfsd_pkg.sv
// Package for the scaled four-digit seven-segment driver.
// Holds widths, the binary-to-BCD step function and the segment table.
// No dependencies.
package sfsd_pkg;

    localparam int DIGIT_COUNT     = 4;
    localparam int IDX_W           = $clog2(DIGIT_COUNT);
    localparam int BIN_W           = 16;
    localparam int SCALE_W         = 8;
    localparam int BCD_DIGITS      = 5;
    localparam int BCD_W           = 4 * BCD_DIGITS;
    localparam int DD_W            = BCD_W + BIN_W;
    localparam int DD_STAGES       = 4;
    localparam int STEPS_PER_STAGE = BIN_W / DD_STAGES;
    localparam int SEL_W           = 8;
    localparam int SEG_W           = 7;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd71;

    typedef logic [DD_W-1:0] dd_word_t;
    typedef logic [DIGIT_COUNT-1:0][3:0] bcd_digits_t;

    typedef struct packed {
        logic        valid;
        bcd_digits_t digits;
    } bcd_item_t;

    function automatic dd_word_t dd_step(dd_word_t x);
        dd_word_t y;
        y = x;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (y[BIN_W + 4 * d +: 4] >= 4'd5)
            begin
                y[BIN_W + 4 * d +: 4] = y[BIN_W + 4 * d +: 4] + 4'd3;
            end
        end
        return {y[DD_W-2:0], 1'b0};
    endfunction

    function automatic dd_word_t dd_stage(dd_word_t x);
        dd_word_t y;
        y = x;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            y = dd_step(y);
        end
        return y;
    endfunction

    function automatic logic [SEG_W-1:0] seg_pattern(logic [3:0] digit);
        logic [SEG_W-1:0] p;
        unique case (digit)
            4'd0:    p = 7'h3f;
            4'd1:    p = 7'h06;
            4'd2:    p = 7'h5b;
            4'd3:    p = 7'h4f;
            4'd4:    p = 7'h66;
            4'd5:    p = 7'h6d;
            4'd6:    p = 7'h7d;
            4'd7:    p = 7'h07;
            4'd8:    p = 7'h7f;
            4'd9:    p = 7'h6f;
            default: p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [SEL_W-1:0] digit_select(logic [IDX_W-1:0] idx);
        logic [SEL_W-1:0] s;
        s = '1;
        s[idx] = 1'b0;
        return s;
    endfunction

endpackage

FILE: hw/rtl/sfsd_bcd_pipe.sv
// Pipelined binary-to-BCD converter, four shift-and-add-3 steps per stage.
// Depends on sfsd_pkg.
module sfsd_bcd_pipe
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sfsd_pkg::BIN_W-1:0]     in_value,
    output sfsd_pkg::bcd_item_t            out_item,
    input  logic                           out_ready
);

    localparam int N = sfsd_pkg::DD_STAGES;

    logic                 valid_reg [N];
    sfsd_pkg::dd_word_t   data_reg  [N];
    logic                 stage_rdy [N+1];
    sfsd_pkg::dd_word_t   stage_in  [N];
    logic                 valid_in  [N];

    assign stage_rdy[N] = out_ready;
    assign in_ready     = stage_rdy[0];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        assign stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];

        if (i == 0)
        begin : g_first
            assign stage_in[i] = {{sfsd_pkg::BCD_W{1'b0}}, in_value};
            assign valid_in[i] = in_valid;
        end
        else
        begin : g_next
            assign stage_in[i] = data_reg[i-1];
            assign valid_in[i] = valid_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (stage_rdy[i])
            begin
                valid_reg[i] <= valid_in[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_rdy[i] && valid_in[i])
            begin
                data_reg[i] <= sfsd_pkg::dd_stage(stage_in[i]);
            end
        end
    end

    assign out_item.valid = valid_reg[N-1];

    for (genvar k = 0; k < sfsd_pkg::DIGIT_COUNT; k++)
    begin : g_digit
        assign out_item.digits[k] =
            data_reg[N-1][sfsd_pkg::BIN_W + 4 * (sfsd_pkg::DIGIT_COUNT - 1 - k) +: 4];
    end

endmodule

FILE: hw/rtl/scaled_four_digit_seven_segment_driver.sv
// Top level of the scaled four-digit seven-segment driver.
// Depends on sfsd_pkg and sfsd_bcd_pipe.
//
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tdata[15:0] speed_count
// m_*      out  m_tvalid/m_tready   m_tdata[7:0] digit_select_n, [14:8] segments; tlast
// cfg_*    in   cfg_wr_en           cfg_wr_data[7:0] speed_scale
//
// Each transfer in yields four transfers out, thousands first, and the output
// serializer sets how often a new count can be taken. From input to the first
// digit a count passes one multiply stage, four conversion stages and the
// serializer. Reset sets the scale to 71 and empties all stages. A stall on the
// output holds every stage without loss.
module scaled_four_digit_seven_segment_driver
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [sfsd_pkg::SCALE_W-1:0]         cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,  // speed_count
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,  // digit_select_n, segments, pad
    output logic                                 m_tlast   // last_digit
);

    localparam int IW = sfsd_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(sfsd_pkg::DIGIT_COUNT - 1);

    logic [sfsd_pkg::SCALE_W-1:0]  scale_reg;
    logic                          mult_valid_reg;
    logic [sfsd_pkg::BIN_W-1:0]    scaled_reg;
    logic                          mult_ready;
    logic                          pipe_in_ready;
    logic [sfsd_pkg::BIN_W+sfsd_pkg::SCALE_W-1:0] product;
    sfsd_pkg::bcd_item_t           pipe_item;
    logic                          ser_ready;
    logic                          ser_take;
    logic                          out_fire;
    logic                          ser_valid_reg;
    logic [IW-1:0]                 idx_reg;
    logic [sfsd_pkg::SEG_W-1:0]    seg_reg [sfsd_pkg::DIGIT_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= sfsd_pkg::SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            scale_reg <= cfg_wr_data;
        end
    end

    assign mult_ready = !mult_valid_reg || pipe_in_ready;
    assign s_tready   = mult_ready;
    assign product    = s_tdata * scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_valid_reg <= 1'b0;
        end
        else if (mult_ready)
        begin
            mult_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mult_ready && s_tvalid)
        begin
            scaled_reg <= product[sfsd_pkg::BIN_W-1:0];
        end
    end

    sfsd_bcd_pipe u_bcd_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid_reg),
        .in_ready  (pipe_in_ready),
        .in_value  (scaled_reg),
        .out_item  (pipe_item),
        .out_ready (ser_ready)
    );

    assign out_fire  = ser_valid_reg && m_tready;
    assign ser_ready = !ser_valid_reg || (out_fire && idx_reg == LAST_IDX);
    assign ser_take  = ser_ready && pipe_item.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (ser_take)
        begin
            ser_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (out_fire && idx_reg == LAST_IDX)
        begin
            ser_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_take)
        begin
            for (int k = 0; k < sfsd_pkg::DIGIT_COUNT; k++)
            begin
                seg_reg[k] <= sfsd_pkg::seg_pattern(pipe_item.digits[k]);
            end
        end
    end

    assign m_tvalid = ser_valid_reg;
    assign m_tlast  = (idx_reg == LAST_IDX);
    assign m_tdata  = {1'b0, seg_reg[idx_reg], sfsd_pkg::digit_select(idx_reg)};

    a_digit_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !m_tlast) |=> (m_tvalid && idx_reg == $past(idx_reg) + IW'(1)))
        else $error("Digit index did not advance after a transfer.");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        ser_take |=> (m_tvalid && idx_reg == '0))
        else $error("A new item did not start at the thousands digit.");

    a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(~m_tdata[sfsd_pkg::SEL_W-1:0]))
        else $error("Digit select does not have exactly one low bit.");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && idx_reg == $past(idx_reg)))
        else $error("Serializer moved while the output was stalled.");

endmodule
